FILE: hw/rtl/tcpv_pkg.sv
// package for the tcp segment receive validator
// holds shared types, verdict codes and protocol constants; no dependencies

package tcpv_pkg;

  localparam int unsigned MAX_SEGMENT_BYTES = 1520;
  localparam int unsigned TCP_PROTO         = 6;
  localparam int unsigned MIN_HEADER        = 20;
  localparam int unsigned OFFSET_BYTE       = 12;
  localparam int unsigned FLAGS_BYTE        = 13;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 240;

  typedef enum logic [2:0] {
    ST_ACCEPT   = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BAD_CSUM = 3'd2,
    ST_BAD_HLEN = 3'd3,
    ST_OVERSIZE = 3'd4
  } status_t;

  // one registered input byte with its pseudo-header address sum
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] src;
    logic [31:0] dst;
    logic [17:0] addr_sum;
  } stage_t;

endpackage

FILE: hw/rtl/tcpv_in_stage.sv
// input register stage of the tcp segment receive validator
// registers one byte transfer and pre-adds the address halves; uses tcpv_pkg

module tcpv_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  tcpv_pkg::stage_t in_item,
  input  logic            core_ready,
  output logic            stg_valid,
  output tcpv_pkg::stage_t stg_item
);

  logic             valid_r;
  tcpv_pkg::stage_t item_r;
  tcpv_pkg::stage_t item_nxt;
  logic [17:0]      addr_sum;

  assign in_tready = !valid_r || core_ready;
  assign stg_valid = valid_r;
  assign stg_item  = item_r;

  assign addr_sum = 18'(in_item.src[31:16]) + 18'(in_item.src[15:0])
                  + 18'(in_item.dst[31:16]) + 18'(in_item.dst[15:0]);

  always_comb begin
    item_nxt          = in_item;
    item_nxt.addr_sum = addr_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: hw/rtl/tcpv_core.sv
// per-segment parse, checksum and verdict with the result register
// keeps segment state and counters; uses tcpv_pkg

module tcpv_core #(
  parameter int unsigned MAX_SEGMENT_BYTES = tcpv_pkg::MAX_SEGMENT_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             stg_valid,
  input  tcpv_pkg::stage_t stg_item,
  output logic             core_ready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [tcpv_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] ones_sum_r, ones_sum_nxt;
  logic [7:0]  pending_high_r, pending_high_nxt;
  logic [31:0] port_pair_r, port_pair_nxt;
  logic [63:0] seq_ack_pair_r, seq_ack_pair_nxt;
  logic [11:0] offset_and_flags_r, offset_and_flags_nxt;
  logic [31:0] accept_counter_r, accept_counter_nxt;
  logic [31:0] drop_counter_r, drop_counter_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [tcpv_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic        step;
  logic [7:0]  b;
  logic [15:0] word;
  logic [16:0] sum_add;
  logic [15:0] sum_upd;
  logic [19:0] total;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [15:0] len;
  logic [5:0]  hlen;
  tcpv_pkg::status_t status;

  localparam logic [15:0] MaxLen = 16'(MAX_SEGMENT_BYTES);
  localparam logic [15:0] MinHdr = 16'(tcpv_pkg::MIN_HEADER);
  localparam logic [5:0]  MinHdr6 = 6'(tcpv_pkg::MIN_HEADER);
  localparam logic [19:0] Proto = 20'(tcpv_pkg::TCP_PROTO);

  assign core_ready = !stg_item.last || !out_valid_r || out_tready;
  assign step       = stg_valid && core_ready;
  assign b          = stg_item.data;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    port_pair_nxt        = port_pair_r;
    seq_ack_pair_nxt     = seq_ack_pair_r;
    offset_and_flags_nxt = offset_and_flags_r;
    case (byte_count_r)
      16'd0:  port_pair_nxt[31:24]    = b;
      16'd1:  port_pair_nxt[23:16]    = b;
      16'd2:  port_pair_nxt[15:8]     = b;
      16'd3:  port_pair_nxt[7:0]      = b;
      16'd4:  seq_ack_pair_nxt[63:56] = b;
      16'd5:  seq_ack_pair_nxt[55:48] = b;
      16'd6:  seq_ack_pair_nxt[47:40] = b;
      16'd7:  seq_ack_pair_nxt[39:32] = b;
      16'd8:  seq_ack_pair_nxt[31:24] = b;
      16'd9:  seq_ack_pair_nxt[23:16] = b;
      16'd10: seq_ack_pair_nxt[15:8]  = b;
      16'd11: seq_ack_pair_nxt[7:0]   = b;
      16'(tcpv_pkg::OFFSET_BYTE): offset_and_flags_nxt[11:8] = b[7:4];
      16'(tcpv_pkg::FLAGS_BYTE):  offset_and_flags_nxt[7:0]  = b;
      default: ;
    endcase
  end

  // odd position closes a pair; even position pads the low byte with zero
  assign word    = byte_count_r[0] ? {pending_high_r, b} : {b, 8'h00};
  assign sum_add = 17'(ones_sum_r) + 17'({pending_high_r, b});
  assign sum_upd = 16'(sum_add[15:0] + 16'(sum_add[16]));

  assign ones_sum_nxt     = byte_count_r[0] ? sum_upd : ones_sum_r;
  assign pending_high_nxt = byte_count_r[0] ? pending_high_r : b;
  assign byte_count_nxt   = (byte_count_r == 16'hFFFF) ? byte_count_r : byte_count_r + 16'd1;
  assign len              = byte_count_nxt;

  assign total = 20'(ones_sum_r) + 20'(word) + 20'(stg_item.addr_sum) + Proto + 20'(len);
  assign fold1 = 17'(total[15:0]) + 17'(total[19:16]);
  assign fold2 = 16'(fold1[15:0] + 16'(fold1[16]));
  assign hlen  = {offset_and_flags_nxt[11:8], 2'b00};

  always_comb begin
    if (len < MinHdr) begin
      status = tcpv_pkg::ST_SHORT;
    end else if (len > MaxLen) begin
      status = tcpv_pkg::ST_OVERSIZE;
    end else if (fold2 != 16'hFFFF) begin
      status = tcpv_pkg::ST_BAD_CSUM;
    end else if (hlen < MinHdr6 || 16'(hlen) > len) begin
      status = tcpv_pkg::ST_BAD_HLEN;
    end else begin
      status = tcpv_pkg::ST_ACCEPT;
    end
  end

  assign accept_counter_nxt = (status == tcpv_pkg::ST_ACCEPT) ?
                              accept_counter_r + 32'd1 : accept_counter_r;
  assign drop_counter_nxt   = (status != tcpv_pkg::ST_ACCEPT) ?
                              drop_counter_r + 32'd1 : drop_counter_r;

  assign out_data_nxt = {5'd0, drop_counter_nxt, accept_counter_nxt, stg_item.dst, stg_item.src,
                         offset_and_flags_nxt[7:0], seq_ack_pair_nxt[31:0],
                         seq_ack_pair_nxt[63:32], port_pair_nxt[15:0], port_pair_nxt[31:16],
                         status};

  assign out_valid_nxt = (step && stg_item.last) || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r       <= '0;
      ones_sum_r         <= '0;
      pending_high_r     <= '0;
      port_pair_r        <= '0;
      seq_ack_pair_r     <= '0;
      offset_and_flags_r <= '0;
      accept_counter_r   <= '0;
      drop_counter_r     <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        if (stg_item.last) begin
          byte_count_r       <= '0;
          ones_sum_r         <= '0;
          pending_high_r     <= '0;
          port_pair_r        <= '0;
          seq_ack_pair_r     <= '0;
          offset_and_flags_r <= '0;
          accept_counter_r   <= accept_counter_nxt;
          drop_counter_r     <= drop_counter_nxt;
        end else begin
          byte_count_r       <= byte_count_nxt;
          ones_sum_r         <= ones_sum_nxt;
          pending_high_r     <= pending_high_nxt;
          port_pair_r        <= port_pair_nxt;
          seq_ack_pair_r     <= seq_ack_pair_nxt;
          offset_and_flags_r <= offset_and_flags_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && stg_item.last) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

FILE: hw/rtl/tcp_segment_rx_validator_unit.sv
// top level of the tcp segment receive validator
// instantiates tcpv_in_stage and tcpv_core; uses tcpv_pkg
//
// channel  direction  transfer moves
// in_      slave      one segment byte with addresses, tlast on the final byte
// out_     master     one verdict with parsed fields and counts per segment
//
// one byte per cycle unless results stall; verdict via input and result registers
// the running checksum register adds each closed byte pair with end-around carry
// reset clears segment state, counters and both valid flags
// a stalled result blocks only the final byte of the next segment

module tcp_segment_rx_validator_unit #(
  parameter int unsigned MAX_SEGMENT_BYTES = tcpv_pkg::MAX_SEGMENT_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tcpv_pkg::IN_DATA_W-1:0]  in_tdata,  // data_byte, src_addr, dst_addr
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status, source_port, dest_port, seq_number, ack_number, tcp_flags,
  // sender_addr, receiver_addr, accepted_total, dropped_total
  output logic [tcpv_pkg::OUT_DATA_W-1:0] out_tdata
);

  tcpv_pkg::stage_t in_item;
  tcpv_pkg::stage_t stg_item;
  logic             stg_valid;
  logic             core_ready;

  always_comb begin
    in_item.data     = in_tdata[7:0];
    in_item.last     = in_tlast;
    in_item.src      = in_tdata[39:8];
    in_item.dst      = in_tdata[71:40];
    in_item.addr_sum = '0;
  end

  tcpv_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .core_ready (core_ready),
    .stg_valid  (stg_valid),
    .stg_item   (stg_item)
  );

  tcpv_core #(
    .MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .stg_valid  (stg_valid),
    .stg_item   (stg_item),
    .core_ready (core_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: hw/rtl/tcpv_checker.sv
// port-level checker for the tcp segment receive validator
// watches the top level ports; bound to tcp_segment_rx_validator_unit

module tcpv_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [tcpv_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tcpv_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic in_last_xfer;
  assign in_last_xfer = in_tvalid && in_tready && in_tlast && (in_tdata == in_tdata);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] == 3'(tcpv_pkg::ST_ACCEPT)) ||
                   (out_tdata[2:0] == 3'(tcpv_pkg::ST_SHORT)) ||
                   (out_tdata[2:0] == 3'(tcpv_pkg::ST_BAD_CSUM)) ||
                   (out_tdata[2:0] == 3'(tcpv_pkg::ST_BAD_HLEN)) ||
                   (out_tdata[2:0] == 3'(tcpv_pkg::ST_OVERSIZE)))
    else $error("undefined verdict code");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_last_xfer, 2))
    else $error("result without a final byte transfer");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind tcp_segment_rx_validator_unit tcpv_checker u_tcpv_checker (.*);
